// ===== hw/rtl/stps_pkg.sv =====
// Shared types, codes and constants for the servo teach/playback sequencer.
package stps_pkg;

	localparam int ACT_W = 3;
	localparam int OP_W  = 4;

	localparam logic [ACT_W-1:0] ACT_MOVE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SAVE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PLAY  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
	localparam logic [ACT_W-1:0] ACT_NOP   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_TICK  = 3'd6;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_BUSY      = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_UNKNOWN   = 3'd3;
	localparam logic [2:0] STS_IDLE_TICK = 3'd4;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_RAMP = 2'd1;
	localparam logic [1:0] MODE_PLAY = 2'd2;

	localparam logic [OP_W-1:0] OP_MOVE      = 4'd0;
	localparam logic [OP_W-1:0] OP_SAVE      = 4'd1;
	localparam logic [OP_W-1:0] OP_PLAY      = 4'd2;
	localparam logic [OP_W-1:0] OP_CLEAR     = 4'd3;
	localparam logic [OP_W-1:0] OP_NOP       = 4'd4;
	localparam logic [OP_W-1:0] OP_UNKNOWN   = 4'd5;
	localparam logic [OP_W-1:0] OP_TICK_RAMP = 4'd6;
	localparam logic [OP_W-1:0] OP_TICK_PLAY = 4'd7;
	localparam logic [OP_W-1:0] OP_TICK_IDLE = 4'd8;
	localparam logic [OP_W-1:0] OP_BUSY      = 4'd9;
	localparam logic [OP_W-1:0] OP_FULL      = 4'd10;

	localparam logic [7:0] MAX_ANGLE = 8'd180;

	// controller -> datapath
	typedef struct packed {
		logic            load;
		logic            rd_zero;
		logic            exec;
		logic [OP_W-1:0] op;
	} stps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] mode;
		logic       full;
	} stps_stat_t;

	function automatic logic [7:0] home_angle(input int idx);
		logic [7:0] a;
		case (idx)
			0, 1:    a = 8'd90;
			2:       a = 8'd140;
			default: a = 8'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/stps_ctrl.sv =====
// Controller: item sequencing and command decode for the sequencer.
module stps_ctrl
	import stps_pkg::*;
#(
	parameter int NUM_JOINTS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACT_W-1:0] action,
	input  logic [1:0]       joint,
	input  stps_stat_t       stat,
	output stps_cmd_t        cmd,
	output logic             busy,
	output logic             done
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic            state_q;
	logic [OP_W-1:0] op_q;
	logic [OP_W-1:0] op_d;
	logic            done_q;
	logic            accept;
	logic            joint_ok;

	assign accept   = start && (state_q == S_IDLE);
	assign joint_ok = (32'(joint) < NUM_JOINTS);

	always_comb begin
		op_d = OP_UNKNOWN;
		if (action == ACT_TICK) begin
			case (stat.mode)
				MODE_RAMP: op_d = OP_TICK_RAMP;
				MODE_PLAY: op_d = OP_TICK_PLAY;
				default:   op_d = OP_TICK_IDLE;
			endcase
		end else if (stat.mode != MODE_IDLE) begin
			op_d = OP_BUSY;
		end else begin
			case (action)
				ACT_MOVE:  op_d = joint_ok ? OP_MOVE : OP_UNKNOWN;
				ACT_SAVE:  op_d = stat.full ? OP_FULL : OP_SAVE;
				ACT_PLAY:  op_d = OP_PLAY;
				ACT_CLEAR: op_d = OP_CLEAR;
				ACT_NOP:   op_d = OP_NOP;
				default:   op_d = OP_UNKNOWN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NOP;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op_d;
						state_q <= S_EXEC;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.load    = accept;
	assign cmd.rd_zero = (action == ACT_PLAY);
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.op      = op_q;
	assign busy        = (state_q == S_EXEC);
	assign done        = done_q;

endmodule

// ===== hw/rtl/stps_datapath.sv =====
// Datapath: joint angles, ramp and playback state, pose memory, result registers.
module stps_datapath
	import stps_pkg::*;
#(
	parameter int NUM_JOINTS = 4,
	parameter int MAX_POSES  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  stps_cmd_t  cmd,
	input  logic [1:0] joint,
	input  logic [7:0] target_angle,
	output stps_stat_t stat,
	output logic [2:0] status,
	output logic       write_valid,
	output logic [1:0] write_joint,
	output logic [7:0] write_angle,
	output logic [4:0] saved_count,
	output logic       motion_busy
);

	localparam int JW    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int PW    = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
	localparam int CW    = $clog2(MAX_POSES + 1);
	localparam int ROW_W = NUM_JOINTS * 8;

	logic [7:0]       ang_q [NUM_JOINTS];
	logic [CW-1:0]    cnt_q;
	logic [1:0]       mode_q;
	logic [1:0]       ramp_joint_q;
	logic [7:0]       ramp_pos_q;
	logic [7:0]       ramp_goal_q;
	logic [CW-1:0]    play_pose_q;
	logic [JW-1:0]    play_joint_q;
	logic [1:0]       joint_q;
	logic [7:0]       target_q;

	logic [ROW_W-1:0] mem [MAX_POSES];
	logic [ROW_W-1:0] rd_row_q;
	logic [ROW_W-1:0] save_row;
	logic [PW-1:0]    rd_addr;

	logic [2:0]       status_q;
	logic             wv_q;
	logic [1:0]       wj_q;
	logic [7:0]       wa_q;
	logic [4:0]       cnt_out_q;
	logic             busy_out_q;

	logic [7:0]       tgt_sat;
	logic [7:0]       cur;
	logic [JW-1:0]    jsel;
	logic [CW-1:0]    pp;
	logic [JW-1:0]    pj;
	logic [CW-1:0]    p_step;
	logic [JW-1:0]    j_step;
	logic [7:0]       rd_ang;
	logic [7:0]       pos_step;

	logic [CW-1:0]    cnt_n;
	logic [1:0]       mode_n;
	logic [1:0]       rj_n;
	logic [7:0]       pos_n;
	logic [7:0]       goal_n;
	logic [CW-1:0]    pose_n;
	logic [JW-1:0]    pj_n;
	logic             ang_we;
	logic [2:0]       sts;
	logic             wv;
	logic [1:0]       wj;
	logic [7:0]       wa;

	assign stat.mode = mode_q;
	assign stat.full = (cnt_q == CW'(MAX_POSES));

	assign tgt_sat = (target_q > MAX_ANGLE) ? MAX_ANGLE : target_q;
	assign jsel    = JW'(joint_q);
	assign cur     = ang_q[jsel];

	// play command restarts from the first entry
	assign pp     = (cmd.op == OP_PLAY) ? '0 : play_pose_q;
	assign pj     = (cmd.op == OP_PLAY) ? '0 : play_joint_q;
	assign j_step = (pj == JW'(NUM_JOINTS - 1)) ? '0 : pj + 1'b1;
	assign p_step = (pj == JW'(NUM_JOINTS - 1)) ? pp + 1'b1 : pp;
	assign rd_ang = rd_row_q[{pj, 3'b000} +: 8];

	assign pos_step = (ramp_pos_q < ramp_goal_q) ? ramp_pos_q + 8'd1 :
	                  (ramp_pos_q > ramp_goal_q) ? ramp_pos_q - 8'd1 : ramp_pos_q;

	assign rd_addr = cmd.rd_zero ? '0 : play_pose_q[PW-1:0];

	always_comb begin
		for (int k = 0; k < NUM_JOINTS; k++) begin
			save_row[k*8 +: 8] = ang_q[k];
		end
	end

	always_comb begin
		cnt_n  = cnt_q;
		mode_n = mode_q;
		rj_n   = ramp_joint_q;
		pos_n  = ramp_pos_q;
		goal_n = ramp_goal_q;
		pose_n = play_pose_q;
		pj_n   = play_joint_q;
		ang_we = 1'b0;
		sts    = STS_OK;
		wv     = 1'b0;
		wj     = '0;
		wa     = '0;
		case (cmd.op)
			OP_MOVE: begin
				rj_n   = joint_q;
				pos_n  = cur;
				goal_n = tgt_sat;
				ang_we = 1'b1;
				mode_n = (cur == tgt_sat) ? MODE_IDLE : MODE_RAMP;
				wv     = 1'b1;
				wj     = joint_q;
				wa     = cur;
			end
			OP_SAVE:  cnt_n = cnt_q + 1'b1;
			OP_CLEAR: cnt_n = '0;
			OP_NOP:   sts = STS_OK;
			OP_PLAY, OP_TICK_PLAY: begin
				pose_n = '0;
				pj_n   = '0;
				if (cnt_q != '0) begin
					pose_n = p_step;
					pj_n   = j_step;
					mode_n = (p_step >= cnt_q) ? MODE_IDLE : MODE_PLAY;
					wv     = 1'b1;
					wj     = 2'(pj);
					wa     = rd_ang;
				end
			end
			OP_TICK_RAMP: begin
				pos_n  = pos_step;
				mode_n = (pos_step == ramp_goal_q) ? MODE_IDLE : mode_q;
				wv     = 1'b1;
				wj     = ramp_joint_q;
				wa     = pos_step;
			end
			OP_TICK_IDLE: sts = STS_IDLE_TICK;
			OP_BUSY:      sts = STS_BUSY;
			OP_FULL:      sts = STS_FULL;
			default:      sts = STS_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_JOINTS; i++) begin
				ang_q[i] <= home_angle(i);
			end
			cnt_q        <= '0;
			mode_q       <= MODE_IDLE;
			ramp_joint_q <= '0;
			ramp_pos_q   <= '0;
			ramp_goal_q  <= '0;
			play_pose_q  <= '0;
			play_joint_q <= '0;
		end else if (cmd.exec) begin
			if (ang_we) begin
				ang_q[jsel] <= tgt_sat;
			end
			cnt_q        <= cnt_n;
			mode_q       <= mode_n;
			ramp_joint_q <= rj_n;
			ramp_pos_q   <= pos_n;
			ramp_goal_q  <= goal_n;
			play_pose_q  <= pose_n;
			play_joint_q <= pj_n;
		end
	end

	// item capture and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			joint_q  <= joint;
			target_q <= target_angle;
		end
		if (cmd.exec) begin
			status_q   <= sts;
			wv_q       <= wv;
			wj_q       <= wj;
			wa_q       <= wa;
			cnt_out_q  <= 5'(cnt_n);
			busy_out_q <= (mode_n != MODE_IDLE);
		end
	end

	// pose memory: one row per pose, read at accept, written at execute
	always_ff @(posedge clk) begin
		if (cmd.exec && (cmd.op == OP_SAVE)) begin
			mem[cnt_q[PW-1:0]] <= save_row;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	assign status      = status_q;
	assign write_valid = wv_q;
	assign write_joint = wj_q;
	assign write_angle = wa_q;
	assign saved_count = cnt_out_q;
	assign motion_busy = busy_out_q;

endmodule

// ===== hw/rtl/servo_teach_playback_sequencer_unit.sv =====
// done is registered from the execute state: it rises at the edge that ends
// the execute step of an item, as busy falls.
// No new item is taken while busy is high; busy is high for one cycle per item
// while the registered pose-memory row read feeds the execute step.
// Reset (arst_n low): idle, no poses stored, joints at home angles; the pose
// memory is not cleared. Results cannot be stalled by the receiver.
module servo_teach_playback_sequencer_unit
	import stps_pkg::*;
#(
	parameter int NUM_JOINTS = 4,
	parameter int MAX_POSES  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] action,
	input  logic [1:0] joint,
	input  logic [7:0] target_angle,
	output logic       done,
	output logic [2:0] status,
	output logic       write_valid,
	output logic [1:0] write_joint,
	output logic [7:0] write_angle,
	output logic [4:0] saved_count,
	output logic       motion_busy
);

	stps_cmd_t  cmd;
	stps_stat_t stat;

	stps_ctrl #(
		.NUM_JOINTS(NUM_JOINTS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.joint (joint),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	stps_datapath #(
		.NUM_JOINTS(NUM_JOINTS),
		.MAX_POSES (MAX_POSES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.joint       (joint),
		.target_angle(target_angle),
		.stat        (stat),
		.status      (status),
		.write_valid (write_valid),
		.write_joint (write_joint),
		.write_angle (write_angle),
		.saved_count (saved_count),
		.motion_busy (motion_busy)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not occupy the block");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without an item two cycles earlier");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && write_valid) |-> (status == STS_OK))
		else $error("servo write with a refusal status");

	a_busy_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STS_BUSY) |-> motion_busy)
		else $error("busy refusal while motion idle");

endmodule

// ===== tb/servo_teach_playback_sequencer_unit_test.sv =====
// Self-checking testbench for the servo teach/playback sequencer: directed and random items.
`timescale 1ns / 100ps

module servo_teach_playback_sequencer_unit_test;
	import stps_pkg::*;

	localparam int N_JOINTS = 4;
	localparam int N_POSES  = 16;
	localparam int CYCLE_LIMIT = 100000;
	localparam int MAX_REPORTS = 10;

	// action codes the package leaves unnamed
	localparam logic [2:0] ACT_UNKNOWN  = 3'd5;
	localparam logic [2:0] ACT_RESERVED = 3'd7;

	typedef struct packed {
		logic [2:0] sts;
		logic       wr_valid;
		logic [1:0] wr_joint;
		logic [7:0] wr_angle;
		logic [4:0] pose_cnt;
		logic       moving;
	} servo_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] action = '0;
	logic [1:0] joint = '0;
	logic [7:0] target_angle = '0;
	logic       busy;
	logic       done;
	logic [2:0] status;
	logic       write_valid;
	logic [1:0] write_joint;
	logic [7:0] write_angle;
	logic [4:0] saved_count;
	logic       motion_busy;

	servo_teach_playback_sequencer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.joint        (joint),
		.target_angle (target_angle),
		.done         (done),
		.status       (status),
		.write_valid  (write_valid),
		.write_joint  (write_joint),
		.write_angle  (write_angle),
		.saved_count  (saved_count),
		.motion_busy  (motion_busy)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the sequencer state
	logic [7:0]  joint_angle [N_JOINTS];
	logic [7:0]  pose_mem [N_POSES][N_JOINTS];
	int unsigned pose_total;
	logic [1:0]  seq_mode;
	logic [1:0]  ramp_jnt;
	logic [7:0]  ramp_pos;
	logic [7:0]  ramp_end;
	int unsigned replay_pose;
	int unsigned replay_jnt;

	servo_result_t expected_writes[$];
	int unsigned   mismatches = 0;
	int unsigned   cycles = 0;
	bit            gaps_on = 1'b1;

	function automatic void push_write(input logic [2:0] sts, input logic wv,
			input logic [1:0] wj, input logic [7:0] wa);
		servo_result_t r;
		r.sts      = sts;
		r.wr_valid = wv;
		r.wr_joint = wv ? wj : 2'd0;
		r.wr_angle = wv ? wa : 8'd0;
		r.pose_cnt = pose_total[4:0];
		r.moving   = (seq_mode != MODE_IDLE);
		expected_writes.push_back(r);
	endfunction

	function automatic void replay_step();
		logic [1:0] wj;
		logic [7:0] wa;
		wj = replay_jnt[1:0];
		wa = pose_mem[replay_pose][replay_jnt];
		replay_jnt++;
		if (replay_jnt >= N_JOINTS) begin
			replay_jnt = 0;
			replay_pose++;
		end
		if (replay_pose >= pose_total)
			seq_mode = MODE_IDLE;
		push_write(STS_OK, 1'b1, wj, wa);
	endfunction

	function automatic void predict_write(input logic [2:0] act, input logic [1:0] jnt,
			input logic [7:0] tgt);
		logic [7:0] goal;
		if (act == ACT_TICK) begin
			if (seq_mode == MODE_RAMP) begin
				if (ramp_pos < ramp_end)
					ramp_pos++;
				else if (ramp_pos > ramp_end)
					ramp_pos--;
				if (ramp_pos == ramp_end)
					seq_mode = MODE_IDLE;
				push_write(STS_OK, 1'b1, ramp_jnt, ramp_pos);
			end else if (seq_mode == MODE_PLAY) begin
				replay_step();
			end else begin
				push_write(STS_IDLE_TICK, 1'b0, 2'd0, 8'd0);
			end
		end else if (seq_mode != MODE_IDLE) begin
			push_write(STS_BUSY, 1'b0, 2'd0, 8'd0);
		end else begin
			case (act)
				ACT_MOVE: begin
					goal = (tgt > MAX_ANGLE) ? MAX_ANGLE : tgt;
					ramp_jnt = jnt;
					ramp_pos = joint_angle[jnt];
					ramp_end = goal;
					joint_angle[jnt] = goal;
					seq_mode = (ramp_pos == ramp_end) ? MODE_IDLE : MODE_RAMP;
					push_write(STS_OK, 1'b1, ramp_jnt, ramp_pos);
				end
				ACT_SAVE: begin
					if (pose_total >= N_POSES) begin
						push_write(STS_FULL, 1'b0, 2'd0, 8'd0);
					end else begin
						for (int i = 0; i < N_JOINTS; i++)
							pose_mem[pose_total][i] = joint_angle[i];
						pose_total++;
						push_write(STS_OK, 1'b0, 2'd0, 8'd0);
					end
				end
				ACT_PLAY: begin
					replay_pose = 0;
					replay_jnt = 0;
					if (pose_total == 0) begin
						push_write(STS_OK, 1'b0, 2'd0, 8'd0);
					end else begin
						seq_mode = MODE_PLAY;
						replay_step();
					end
				end
				ACT_CLEAR: begin
					pose_total = 0;
					push_write(STS_OK, 1'b0, 2'd0, 8'd0);
				end
				ACT_NOP: push_write(STS_OK, 1'b0, 2'd0, 8'd0);
				default: push_write(STS_UNKNOWN, 1'b0, 2'd0, 8'd0);
			endcase
		end
	endfunction

	// sends one item; returns at the edge that accepted it
	task automatic send_item(input logic [2:0] act, input logic [1:0] jnt, input logic [7:0] tgt);
		if (gaps_on && $urandom_range(0, 99) < 37) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start        <= 1'b1;
		action       <= act;
		joint        <= jnt;
		target_angle <= tgt;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_write(act, jnt, tgt);
	endtask

	task automatic run_out_motion();
		while (seq_mode != MODE_IDLE)
			send_item(ACT_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	task automatic test_idle_actions();
		send_item(ACT_TICK, 2'd0, 8'd0);
		send_item(ACT_NOP, 2'd3, 8'd255);
		send_item(ACT_UNKNOWN, 2'd1, 8'd10);
		send_item(ACT_RESERVED, 2'd2, 8'd200);
		send_item(ACT_PLAY, 2'd0, 8'd0);
		send_item(ACT_CLEAR, 2'd0, 8'd0);
	endtask

	task automatic test_move_ramp();
		// joint 3 already at 0: one write, no ramp
		send_item(ACT_MOVE, 2'd3, 8'd0);
		send_item(ACT_MOVE, 2'd1, 8'd87);
		send_item(ACT_NOP, 2'd0, 8'd0);
		send_item(ACT_SAVE, 2'd0, 8'd0);
		send_item(ACT_MOVE, 2'd0, 8'd5);
		run_out_motion();
		send_item(ACT_MOVE, 2'd0, 8'd93);
		run_out_motion();
	endtask

	task automatic test_angle_clamp();
		send_item(ACT_MOVE, 2'd2, 8'd255);
		run_out_motion();
		send_item(ACT_MOVE, 2'd2, 8'd181);
	endtask

	task automatic test_playback();
		send_item(ACT_SAVE, 2'd0, 8'd0);
		send_item(ACT_MOVE, 2'd3, 8'd2);
		run_out_motion();
		send_item(ACT_SAVE, 2'd0, 8'd0);
		send_item(ACT_PLAY, 2'd0, 8'd0);
		send_item(ACT_TICK, 2'd0, 8'd0);
		send_item(ACT_RESERVED, 2'd0, 8'd0);
		send_item(ACT_PLAY, 2'd0, 8'd0);
		run_out_motion();
		send_item(ACT_CLEAR, 2'd0, 8'd0);
		send_item(ACT_PLAY, 2'd0, 8'd0);
	endtask

	task automatic test_store_full();
		while (pose_total < N_POSES)
			send_item(ACT_SAVE, 2'd0, 8'd0);
		send_item(ACT_SAVE, 2'd0, 8'd0);
		send_item(ACT_CLEAR, 2'd0, 8'd0);
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int pick;
		int goal;
		logic [1:0] jnt;
		sent = 0;
		while (sent < n_items) begin
			gaps_on = !(sent >= 200 && sent < 320);
			pick = $urandom_range(0, 99);
			jnt  = 2'($urandom_range(0, 3));
			if (pick < 40) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						goal = int'(joint_angle[jnt]) + $urandom_range(0, 16) - 8;
						if (goal < 0) goal = 0;
						if (goal > 180) goal = 180;
					end
					6, 7: goal = $urandom_range(0, 255);
					8: begin
						case ($urandom_range(0, 3))
							0: goal = 0;
							1: goal = 180;
							2: goal = 181;
							default: goal = 255;
						endcase
					end
					default: goal = int'(joint_angle[jnt]);
				endcase
				send_item(ACT_MOVE, jnt, 8'(goal));
			end else if (pick < 55) begin
				send_item(ACT_SAVE, jnt, 8'($urandom_range(0, 255)));
			end else if (pick < 65) begin
				send_item(ACT_PLAY, jnt, 8'($urandom_range(0, 255)));
			end else if (pick < 70) begin
				send_item(ACT_CLEAR, jnt, 8'($urandom_range(0, 255)));
			end else if (pick < 88) begin
				send_item(3'($urandom_range(0, 7)), jnt, 8'($urandom_range(0, 255)));
			end else begin
				send_item(ACT_TICK, jnt, 8'($urandom_range(0, 255)));
			end
			sent++;
			// tick the motion out, with a refused command now and then
			while (seq_mode != MODE_IDLE) begin
				if ($urandom_range(0, 9) == 0)
					send_item(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
				else
					send_item(ACT_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	function automatic void note_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on %s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_writes
		servo_result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with no item pending: status %0d", status);
			end else begin
				want = expected_writes.pop_front();
				note_field("status", 32'(want.sts), 32'(status));
				note_field("write_valid", 32'(want.wr_valid), 32'(write_valid));
				note_field("write_joint", 32'(want.wr_joint), 32'(write_joint));
				note_field("write_angle", 32'(want.wr_angle), 32'(write_angle));
				note_field("saved_count", 32'(want.pose_cnt), 32'(saved_count));
				note_field("motion_busy", 32'(want.moving), 32'(motion_busy));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("servo_teach_playback_sequencer_unit_test: errors");
			$finish;
		end
	end

	initial begin
		joint_angle[0] = 8'd90;
		joint_angle[1] = 8'd90;
		joint_angle[2] = 8'd140;
		joint_angle[3] = 8'd0;
		pose_total  = 0;
		seq_mode    = MODE_IDLE;
		ramp_jnt    = '0;
		ramp_pos    = '0;
		ramp_end    = '0;
		replay_pose = 0;
		replay_jnt  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_actions();
		test_move_ramp();
		test_angle_clamp();
		test_playback();
		test_store_full();
		test_random(500);

		start <= 1'b0;
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("servo_teach_playback_sequencer_unit_test: clean");
		else
			$display("servo_teach_playback_sequencer_unit_test: errors");
		$finish;
	end

endmodule
